// ===== hdl/dtg_pkg.sv =====
// Shared types, constants and register codes for the touch-tone Goertzel decoder.
// No dependencies; the decoder and dtg_isqrt refer to this package by scoped names.
package dtg_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int ACC_BITS_DEF = 40;

    // configuration register indexes
    localparam logic [2:0] CFG_BLOCK_SIZE = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT    = 3'd1;
    localparam logic [2:0] CFG_THRESHOLD  = 3'd2;
    localparam logic [2:0] CFG_COEF_LOW   = 3'd3;
    localparam logic [2:0] CFG_COEF_HIGH  = 3'd4;

    localparam logic [11:0] BLOCK_SIZE_RST = 12'd205;
    localparam logic [15:0] TIMEOUT_RST    = 16'd195;
    localparam logic [11:0] THRESHOLD_RST  = 12'd445;

    localparam logic [4:0] NO_KEY = 5'd16;

    // result event codes
    localparam logic [1:0] EV_MID     = 2'd0;
    localparam logic [1:0] EV_BLOCK   = 2'd1;
    localparam logic [1:0] EV_KEY     = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    typedef struct packed {
        logic               channel;
        logic signed [15:0] sample;
    } in_word_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [3:0] key;
        logic       carrier;
    } out_word_t;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } sqrt_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_MUL,
        ST_UPD_WR,
        ST_COUNT,
        ST_MAX_RD,
        ST_MAX_ACC,
        ST_SHIFT,
        ST_PW_RD,
        ST_PW_AB,
        ST_PW_AA,
        ST_PW_BB,
        ST_PW_AC,
        ST_PW_TB,
        ST_PW_SUB,
        ST_ROOT,
        ST_PICK_MUL,
        ST_PICK_CMP,
        ST_DECIDE,
        ST_OUT
    } state_t;

endpackage

// ===== hdl/dtmf_goertzel_decoder.sv =====
// Touch-tone decoder: per channel, eight Goertzel resonators fed by each sample word;
// at the end of each block the magnitudes are tested for row and column dominance and
// debounced into keys. Uses dtg_pkg, dtg_mult, dtg_isqrt and dtg_resmem.
//
// One sample word is taken at a time and s_ready stays low while it is processed. A
// mid-block sample steps each tone through read, multiply and write on the shared
// multiplier and resonator memory port, then updates the block count and hands off.
// A block-ending sample adds a peak search, a normalising shift, the power terms per
// tone on the shared multiplier and the 32-step square root unit, and the dominance
// tests. Results sit in an output register, so the next sample word is taken while
// one waits.
module dtmf_goertzel_decoder #(
    parameter int CHANNELS = dtg_pkg::CHANNELS_DEF,
    parameter int ACC_BITS = dtg_pkg::ACC_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dtg_pkg::in_word_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dtg_pkg::out_word_t  m_data,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_wdata
);

    localparam int CW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW   = CW + 3;
    localparam int MA   = (ACC_BITS > 36) ? ACC_BITS : 36;
    localparam int PW   = MA + 32;
    localparam int SW   = ACC_BITS + 4;

    // configuration
    logic [11:0] block_size_reg;
    logic [15:0] timeout_reg;
    logic [11:0] thr_reg;
    logic [63:0] coef_lo_reg;
    logic [63:0] coef_hi_reg;

    // per-channel decision state
    logic [11:0] cnt_reg     [CHANNELS];
    logic [4:0]  last_reg    [CHANNELS];
    logic [4:0]  acc_key_reg [CHANNELS];
    logic [4:0]  prior_reg   [CHANNELS];
    logic [15:0] inact_reg   [CHANNELS];
    logic        carrier_reg [CHANNELS];

    dtg_pkg::state_t state_reg, state_next;

    logic [CW-1:0]              ch_reg;
    logic signed [15:0]         sample_reg;
    logic [2:0]                 tone_reg;
    logic [ACC_BITS-1:0]        maxq_reg;
    logic [5:0]                 shift_reg;
    logic signed [31:0]         a_reg;
    logic signed [31:0]         b_reg;
    logic signed [63:0]         pw_reg;
    logic [31:0]                mag_reg [8];
    logic [33:0]                gsum_reg [2];
    logic                       grp_reg;
    logic [1:0]                 pi_reg;
    logic                       row_ok_reg, col_ok_reg;
    logic [1:0]                 row_reg, col_reg;
    dtg_pkg::out_word_t         pend_reg;
    dtg_pkg::out_word_t         m_data_reg;
    logic                       m_valid_reg;

    // shared datapath signals
    logic signed [MA-1:0]       mult_a;
    logic signed [31:0]         mult_b;
    logic signed [PW-1:0]       prod;
    logic signed [ACC_BITS-1:0] rd_q1, rd_q2;
    logic signed [15:0]         coef_cur;
    logic signed [SW-1:0]       q0_wide;
    logic signed [ACC_BITS-1:0] q0_sat;
    logic [ACC_BITS-1:0]        abs1, abs2, maxq_sh;
    logic signed [63:0]         pw_fin;
    logic [31:0]                mag_sel;
    logic [33:0]                others;
    logic                       win;
    logic                       chan_ok;
    logic                       out_free;
    logic [11:0]                cnt_inc;
    dtg_pkg::sqrt_req_t         sq_req;
    dtg_pkg::sqrt_rsp_t         sq_rsp;

    // block decision
    logic [4:0]  decoded;
    logic        same;
    logic [4:0]  acc_new;
    logic        carrier_new;
    logic [15:0] inact_new;
    logic [1:0]  ev_new;
    logic [3:0]  key_new;

    assign chan_ok  = {31'd0, s_data.channel} < 32'(CHANNELS);
    assign out_free = !m_valid_reg || m_ready;
    assign cnt_inc  = cnt_reg[ch_reg] + 12'd1;
    assign coef_cur = tone_reg[2] ? coef_hi_reg[16*tone_reg[1:0] +: 16]
                                  : coef_lo_reg[16*tone_reg[1:0] +: 16];

    assign q0_wide = SW'(sample_reg) + SW'((prod + PW'(8192)) >>> 14) - SW'(rd_q2);
    always_comb begin
        if (q0_wide[SW-1:ACC_BITS-1] == '0 || q0_wide[SW-1:ACC_BITS-1] == '1) begin
            q0_sat = q0_wide[ACC_BITS-1:0];
        end else begin
            q0_sat = {q0_wide[SW-1], {(ACC_BITS-1){~q0_wide[SW-1]}}};
        end
    end

    assign abs1    = rd_q1[ACC_BITS-1] ? (~rd_q1 + 1'b1) : rd_q1;
    assign abs2    = rd_q2[ACC_BITS-1] ? (~rd_q2 + 1'b1) : rd_q2;
    assign maxq_sh = maxq_reg >> shift_reg;
    assign pw_fin  = pw_reg - 64'(prod);
    assign mag_sel = mag_reg[{grp_reg, pi_reg}];
    assign others  = gsum_reg[grp_reg] - {2'b00, mag_sel};
    assign win     = {16'd0, mag_sel, 8'd0} > 56'(prod);

    assign sq_req.start = (state_reg == dtg_pkg::ST_PW_SUB);
    assign sq_req.value = pw_fin[63] ? 64'd0 : pw_fin;

    // operand selection for the shared multiplier
    always_comb begin
        mult_a = '0;
        mult_b = '0;
        unique case (state_reg)
            dtg_pkg::ST_UPD_MUL: begin
                mult_a = MA'(rd_q1);
                mult_b = 32'(coef_cur);
            end
            dtg_pkg::ST_PW_AA: begin
                mult_a = MA'(a_reg);
                mult_b = a_reg;
            end
            dtg_pkg::ST_PW_BB: begin
                mult_a = MA'(b_reg);
                mult_b = b_reg;
            end
            dtg_pkg::ST_PW_AC: begin
                mult_a = MA'(a_reg);
                mult_b = 32'(coef_cur);
            end
            dtg_pkg::ST_PW_TB: begin
                mult_a = MA'(prod >>> 14);
                mult_b = b_reg;
            end
            dtg_pkg::ST_PICK_MUL: begin
                mult_a = MA'(others);
                mult_b = 32'(thr_reg);
            end
            default: begin
                mult_a = '0;
                mult_b = '0;
            end
        endcase
    end

    always_comb begin
        decoded     = (row_ok_reg && col_ok_reg) ? {1'b0, row_reg, col_reg} : dtg_pkg::NO_KEY;
        same        = (decoded == last_reg[ch_reg]);
        acc_new     = same ? decoded : acc_key_reg[ch_reg];
        carrier_new = same ? (decoded != dtg_pkg::NO_KEY) : carrier_reg[ch_reg];
        inact_new   = (same && decoded != dtg_pkg::NO_KEY) ? timeout_reg : inact_reg[ch_reg];
        ev_new      = dtg_pkg::EV_BLOCK;
        key_new     = 4'd0;
        if (acc_new != prior_reg[ch_reg] && acc_new != dtg_pkg::NO_KEY) begin
            ev_new  = dtg_pkg::EV_KEY;
            key_new = acc_new[3:0];
        end else if (inact_new != 16'd0) begin
            inact_new = inact_new - 16'd1;
            if (inact_new == 16'd0) begin
                ev_new = dtg_pkg::EV_TIMEOUT;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dtg_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = chan_ok ? dtg_pkg::ST_UPD_RD : dtg_pkg::ST_OUT;
                end
            end
            dtg_pkg::ST_UPD_RD:  state_next = dtg_pkg::ST_UPD_MUL;
            dtg_pkg::ST_UPD_MUL: state_next = dtg_pkg::ST_UPD_WR;
            dtg_pkg::ST_UPD_WR: begin
                state_next = (tone_reg == 3'd7) ? dtg_pkg::ST_COUNT : dtg_pkg::ST_UPD_RD;
            end
            dtg_pkg::ST_COUNT: begin
                state_next = (cnt_inc == block_size_reg) ? dtg_pkg::ST_MAX_RD : dtg_pkg::ST_OUT;
            end
            dtg_pkg::ST_MAX_RD:  state_next = dtg_pkg::ST_MAX_ACC;
            dtg_pkg::ST_MAX_ACC: begin
                state_next = (tone_reg == 3'd7) ? dtg_pkg::ST_SHIFT : dtg_pkg::ST_MAX_RD;
            end
            dtg_pkg::ST_SHIFT: begin
                if (!(|maxq_sh[ACC_BITS-1:30])) begin
                    state_next = dtg_pkg::ST_PW_RD;
                end
            end
            dtg_pkg::ST_PW_RD:  state_next = dtg_pkg::ST_PW_AB;
            dtg_pkg::ST_PW_AB:  state_next = dtg_pkg::ST_PW_AA;
            dtg_pkg::ST_PW_AA:  state_next = dtg_pkg::ST_PW_BB;
            dtg_pkg::ST_PW_BB:  state_next = dtg_pkg::ST_PW_AC;
            dtg_pkg::ST_PW_AC:  state_next = dtg_pkg::ST_PW_TB;
            dtg_pkg::ST_PW_TB:  state_next = dtg_pkg::ST_PW_SUB;
            dtg_pkg::ST_PW_SUB: state_next = dtg_pkg::ST_ROOT;
            dtg_pkg::ST_ROOT: begin
                if (sq_rsp.done) begin
                    state_next = (tone_reg == 3'd7) ? dtg_pkg::ST_PICK_MUL : dtg_pkg::ST_PW_RD;
                end
            end
            dtg_pkg::ST_PICK_MUL: state_next = dtg_pkg::ST_PICK_CMP;
            dtg_pkg::ST_PICK_CMP: begin
                if ((win || pi_reg == 2'd3) && grp_reg) begin
                    state_next = dtg_pkg::ST_DECIDE;
                end else begin
                    state_next = dtg_pkg::ST_PICK_MUL;
                end
            end
            dtg_pkg::ST_DECIDE: state_next = dtg_pkg::ST_OUT;
            dtg_pkg::ST_OUT: begin
                if (out_free) begin
                    state_next = dtg_pkg::ST_IDLE;
                end
            end
            default: state_next = dtg_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dtg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg <= dtg_pkg::BLOCK_SIZE_RST;
            timeout_reg    <= dtg_pkg::TIMEOUT_RST;
            thr_reg        <= dtg_pkg::THRESHOLD_RST;
            coef_lo_reg    <= '0;
            coef_hi_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                dtg_pkg::CFG_BLOCK_SIZE: block_size_reg <= cfg_wdata[11:0];
                dtg_pkg::CFG_TIMEOUT:    timeout_reg    <= cfg_wdata[15:0];
                dtg_pkg::CFG_THRESHOLD:  thr_reg        <= cfg_wdata[11:0];
                dtg_pkg::CFG_COEF_LOW:   coef_lo_reg    <= cfg_wdata;
                dtg_pkg::CFG_COEF_HIGH:  coef_hi_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < CHANNELS; c++) begin
                cnt_reg[c]     <= '0;
                last_reg[c]    <= dtg_pkg::NO_KEY;
                acc_key_reg[c] <= dtg_pkg::NO_KEY;
                prior_reg[c]   <= dtg_pkg::NO_KEY;
                inact_reg[c]   <= '0;
                carrier_reg[c] <= 1'b0;
            end
        end else begin
            if (state_reg == dtg_pkg::ST_COUNT) begin
                cnt_reg[ch_reg] <= (cnt_inc == block_size_reg) ? 12'd0 : cnt_inc;
            end
            if (state_reg == dtg_pkg::ST_DECIDE) begin
                last_reg[ch_reg]    <= decoded;
                acc_key_reg[ch_reg] <= acc_new;
                prior_reg[ch_reg]   <= acc_new;
                inact_reg[ch_reg]   <= inact_new;
                carrier_reg[ch_reg] <= carrier_new;
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            dtg_pkg::ST_IDLE: begin
                ch_reg     <= CW'(s_data.channel);
                sample_reg <= s_data.sample;
                tone_reg   <= '0;
                pend_reg   <= '0;
            end
            dtg_pkg::ST_UPD_WR: tone_reg <= tone_reg + 3'd1;
            dtg_pkg::ST_COUNT: begin
                maxq_reg       <= '0;
                shift_reg      <= '0;
                gsum_reg[0]    <= '0;
                gsum_reg[1]    <= '0;
                pend_reg       <= '{dtg_pkg::EV_MID, 4'd0, carrier_reg[ch_reg]};
            end
            dtg_pkg::ST_MAX_ACC: begin
                if (abs1 > maxq_reg && abs1 >= abs2) begin
                    maxq_reg <= abs1;
                end else if (abs2 > maxq_reg) begin
                    maxq_reg <= abs2;
                end
                tone_reg <= tone_reg + 3'd1;
            end
            dtg_pkg::ST_SHIFT: begin
                if (|maxq_sh[ACC_BITS-1:30]) begin
                    shift_reg <= shift_reg + 6'd1;
                end
            end
            dtg_pkg::ST_PW_AB: begin
                a_reg <= 32'(rd_q1 >>> shift_reg);
                b_reg <= 32'(rd_q2 >>> shift_reg);
            end
            dtg_pkg::ST_PW_BB: pw_reg <= 64'(prod);
            dtg_pkg::ST_PW_AC: pw_reg <= pw_reg + 64'(prod);
            dtg_pkg::ST_ROOT: begin
                if (sq_rsp.done) begin
                    mag_reg[tone_reg]     <= sq_rsp.root;
                    gsum_reg[tone_reg[2]] <= gsum_reg[tone_reg[2]] + {2'b00, sq_rsp.root};
                    tone_reg              <= tone_reg + 3'd1;
                    grp_reg               <= 1'b0;
                    pi_reg                <= '0;
                end
            end
            dtg_pkg::ST_PICK_CMP: begin
                // first dominant tone of the group wins; advance to columns after rows
                if (win || pi_reg == 2'd3) begin
                    if (grp_reg) begin
                        col_ok_reg <= win;
                        col_reg    <= pi_reg;
                    end else begin
                        row_ok_reg <= win;
                        row_reg    <= pi_reg;
                    end
                    grp_reg <= 1'b1;
                    pi_reg  <= '0;
                end else begin
                    pi_reg <= pi_reg + 2'd1;
                end
            end
            dtg_pkg::ST_DECIDE: pend_reg <= '{ev_new, key_new, carrier_new};
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == dtg_pkg::ST_OUT && out_free) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == dtg_pkg::ST_OUT && out_free) begin
            m_data_reg <= pend_reg;
        end
    end

    assign s_ready = (state_reg == dtg_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    dtg_mult #(
        .A_BITS (MA)
    ) u_mult (
        .aclk     (aclk),
        .op_a     (mult_a),
        .op_b     (mult_b),
        .prod_reg (prod)
    );

    dtg_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    dtg_resmem #(
        .ACC_BITS (ACC_BITS),
        .AW       (AW)
    ) u_resmem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (state_reg == dtg_pkg::ST_UPD_RD || state_reg == dtg_pkg::ST_MAX_RD ||
                   state_reg == dtg_pkg::ST_PW_RD),
        .rd_addr  ({ch_reg, tone_reg}),
        .rd_q1    (rd_q1),
        .rd_q2    (rd_q2),
        .wr_en    (state_reg == dtg_pkg::ST_UPD_WR),
        .wr_addr  ({ch_reg, tone_reg}),
        .wr_q1    (q0_sat),
        .wr_q2    (rd_q1),
        .clr_en   (state_reg == dtg_pkg::ST_PW_AB),
        .clr_addr ({ch_reg, tone_reg})
    );

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("sample word taken while previous still in progress");

    a_shift_normalised: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == dtg_pkg::ST_PW_RD |-> !(|maxq_sh[ACC_BITS-1:30]))
        else $error("power terms started before normalising shift settled");

    a_key_only_on_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_res != dtg_pkg::EV_KEY |-> m_data.key == 4'd0)
        else $error("key field set on a non-key result");

endmodule

// ===== hdl/dtg_mult.sv =====
// Shared signed multiplier with a registered product.
// Depends on nothing beyond its parameters.
module dtg_mult #(
    parameter int A_BITS = 40
) (
    input  logic                       aclk,
    input  logic signed [A_BITS-1:0]   op_a,
    input  logic signed [31:0]         op_b,
    output logic signed [A_BITS+31:0]  prod_reg
);

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
    end

endmodule

// ===== hdl/dtg_isqrt.sv =====
// Bit-pair integer square root, one step per cycle, 32 steps per root.
// Depends on dtg_pkg for the request and response structs.
module dtg_isqrt (
    input  logic               aclk,
    input  logic               aresetn,
    input  dtg_pkg::sqrt_req_t req,
    output dtg_pkg::sqrt_rsp_t rsp
);

    logic [63:0] rem_reg;
    logic [63:0] res_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [63:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                rem_reg  <= req.value;
                res_reg  <= '0;
                bit_reg  <= 64'd1 << 62;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (rem_reg >= trial) begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end else begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("root started while a root is in progress");

endmodule

// ===== hdl/dtg_resmem.sv =====
// Resonator state memory: one word of both delay taps per channel and tone.
// Per-entry valid bits make unwritten or cleared entries read as zero.
module dtg_resmem #(
    parameter int ACC_BITS = 40,
    parameter int AW       = 4
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [AW-1:0]              rd_addr,
    output logic signed [ACC_BITS-1:0] rd_q1,
    output logic signed [ACC_BITS-1:0] rd_q2,
    input  logic                       wr_en,
    input  logic [AW-1:0]              wr_addr,
    input  logic signed [ACC_BITS-1:0] wr_q1,
    input  logic signed [ACC_BITS-1:0] wr_q2,
    input  logic                       clr_en,
    input  logic [AW-1:0]              clr_addr
);

    localparam int DEPTH = 1 << AW;

    logic [2*ACC_BITS-1:0] mem [DEPTH];
    logic [2*ACC_BITS-1:0] data_reg;
    logic [DEPTH-1:0]      vld_reg;
    logic                  hit_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= {wr_q1, wr_q2};
        end
        if (rd_en) begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            if (clr_en) begin
                vld_reg[clr_addr] <= 1'b0;
            end
            if (rd_en) begin
                hit_reg <= vld_reg[rd_addr];
            end
        end
    end

    assign rd_q1 = hit_reg ? data_reg[2*ACC_BITS-1:ACC_BITS] : '0;
    assign rd_q2 = hit_reg ? data_reg[ACC_BITS-1:0] : '0;

    a_wr_clr_apart: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_en && clr_en))
        else $error("write and clear in the same cycle");

endmodule
